// ===== rtl/sha_pkg.sv =====
// SHA-256 block update: shared types, constants and round functions.
// Depends on nothing; imported by the top level.
`default_nettype none

package sha_pkg;

   localparam int BLOCK_WORDS  = 16;
   localparam int ROUNDS       = 64;
   localparam int DIGEST_WORDS = 8;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef logic [31:0] word_type;

   // Standard initial hash value, H0 first
   localparam word_type SHA_IV [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Round constant table
   function automatic word_type round_const(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_block_update.sv =====
// SHA-256 block update: message window, round unit, chaining value, digest output.
// Depends on sha_pkg.
`default_nettype none

// Usage
//   req_ channel: one 32-bit big-endian message word per beat, with restart
//   (reload the initial hash and drop any partial block) and message_end.
//   rsp_ channel: eight digest words, H0 first, word_index 0..7, last_word on 7,
//   sent only when the word that completes a block carries message_end.
// Timing
//   Words 1 to 15 of a block are taken one per cycle. The sixteenth word starts
//   64 rounds on the single round unit (one round and one schedule word
//   per cycle), then the fold state adds the result into the chaining value.
//   Digest words follow from the cycle after the fold, one per rsp beat.
//   req_ready is low from the sixteenth word until the fold is done, and,
//   when a digest is due, until its last word has been taken.
// Reset
//   Synchronous, active high: chaining value back to the initial hash,
//   word and round counters cleared, no digest pending.
// Stalls
//   A stalled rsp beat holds its word; the block waits without losing state.
module sha256_block_update (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [31:0]           req_message_word,
   input  wire                   req_restart,
   input  wire                   req_message_end,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [31:0]           rsp_digest_word,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word
);
   import sha_pkg::*;

   localparam logic [3:0] CNT_LAST = 4'(BLOCK_WORDS - 1);
   localparam logic [5:0] RND_LAST = 6'(ROUNDS - 1);
   localparam logic [2:0] IDX_LAST = 3'(DIGEST_WORDS - 1);

   state_type state_ff, state_in;

   word_type   win_ff   [BLOCK_WORDS];
   word_type   win_in   [BLOCK_WORDS];
   word_type   work_ff  [DIGEST_WORDS];
   word_type   work_in  [DIGEST_WORDS];
   word_type   chain_ff [DIGEST_WORDS];
   word_type   chain_in [DIGEST_WORDS];
   logic [3:0] cnt_ff, cnt_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;
   logic       end_ff, end_in;

   logic       req_beat;
   logic       rsp_beat;
   logic [3:0] cnt_base;
   logic       block_full;
   word_type   t1, t2, w_next;

   assign req_beat   = req_valid & req_ready;
   assign rsp_beat   = rsp_valid & rsp_ready;
   assign cnt_base   = req_restart ? 4'd0 : cnt_ff;
   assign block_full = (cnt_base == CNT_LAST);

   // Round unit and schedule extension, shared by all 64 rounds
   assign t1 = work_ff[7] + big_sig1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + round_const(rnd_ff) + win_ff[0];
   assign t2 = big_sig0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign w_next = win_ff[0] + small_sig0(win_ff[1]) + win_ff[9] + small_sig1(win_ff[14]);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_beat && block_full) state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == RND_LAST) state_in = ST_FOLD;
         ST_FOLD:  state_in = end_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:  if (rsp_beat && idx_ff == IDX_LAST) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_EMIT:  rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_digest_word = chain_ff[0];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == IDX_LAST);

   // Datapath next values
   always_comb begin
      win_in   = win_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               // shift the word into the window; reload the hash on restart
               for (int i = 0; i < BLOCK_WORDS - 1; i++) win_in[i] = win_ff[i + 1];
               win_in[BLOCK_WORDS - 1] = req_message_word;
               if (req_restart) chain_in = SHA_IV;
               cnt_in = cnt_base + 4'd1;
               end_in = req_message_end;
               rnd_in = 6'd0;
               idx_in = 3'd0;
               work_in = chain_ff;
            end
         end
         ST_ROUND: begin
            // advance one round and one schedule word
            for (int i = 0; i < BLOCK_WORDS - 1; i++) win_in[i] = win_ff[i + 1];
            win_in[BLOCK_WORDS - 1] = w_next;
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            rnd_in = rnd_ff + 6'd1;
         end
         ST_FOLD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) chain_in[i] = chain_ff[i] + work_ff[i];
         end
         ST_EMIT: begin
            // rotate the chaining value; eight beats bring it back in place
            if (rsp_beat) begin
               for (int i = 0; i < DIGEST_WORDS - 1; i++) chain_in[i] = chain_ff[i + 1];
               chain_in[DIGEST_WORDS - 1] = chain_ff[0];
               idx_in = idx_ff + 3'd1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 4'd0;
         rnd_ff   <= 6'd0;
         idx_ff   <= 3'd0;
         end_ff   <= 1'b0;
         chain_ff <= SHA_IV;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         end_ff   <= end_in;
         chain_ff <= chain_in;
      end
   end

   // Window and working variables
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
   end

endmodule

`default_nettype wire

// ===== rtl/sha_chk.sv =====
// Port-level checker for sha256_block_update, and its bind.
// Depends only on the top level's ports.
`default_nettype none

module sha_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire [31:0] req_message_word,
   input wire        req_restart,
   input wire        req_message_end,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_digest_word,
   input wire [2:0]  rsp_word_index,
   input wire        rsp_last_word
);

   // Hold a stalled digest beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
                                  && $stable(rsp_word_index))
      else $error("stalled digest beat changed");

   // No new message word while a digest is going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready during digest output");

   // Last flag marks exactly word seven
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word_index");

   // Digest words run in order without a gap
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word
         |=> rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word sequence broken");

   // A digest starts at word zero
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_word_index == 3'd0)
      else $error("digest did not start at word zero");

endmodule

bind sha256_block_update sha_chk u_sha_chk (.*);

`default_nettype wire
